/* src/lcd_parallel_write_sequencer_unit_assert.svh */
// Assertion macros shared by the LCD write sequencer modules.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef LCD_PARALLEL_WRITE_SEQUENCER_UNIT_ASSERT_SVH
`define LCD_PARALLEL_WRITE_SEQUENCER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define LCDPWS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset
`define LCDPWS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/lcdpws_pkg.sv */
// Package for the LCD parallel write sequencer: codes, item types, constants.
// No dependencies.
`timescale 1ns / 1ps

package lcdpws_pkg;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_BUS_MODE   = 3'd0,
		CFG_PULSE      = 3'd1,
		CFG_SHORT_WAIT = 3'd2,
		CFG_CLEAR_WAIT = 3'd3,
		CFG_POWER_UP   = 3'd4
	} cfg_idx_t;

	// Request kinds on the input channel; the two top codes act as a tick
	typedef enum logic [2:0] {
		KIND_TICK    = 3'd0,
		KIND_COMMAND = 3'd1,
		KIND_CHAR    = 3'd2,
		KIND_CURSOR  = 3'd3,
		KIND_CLEAR   = 3'd4,
		KIND_INIT    = 3'd5
	} kind_t;

	// Sequencer phases
	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_POWER   = 3'd1,
		PH_HIGH    = 3'd2,
		PH_LOW     = 3'd3,
		PH_NIBWAIT = 3'd4,
		PH_AFTER   = 3'd5
	} phase_t;

	// Classified operation passed from front to back
	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_BYTE = 2'd1,
		OP_INIT = 2'd2
	} op_t;

	// Which configured wait follows a byte
	typedef enum logic [1:0] {
		DWELL_NONE  = 2'd0,
		DWELL_SHORT = 2'd1,
		DWELL_CLEAR = 2'd2
	} dwell_sel_t;

	// Classified item held in the queue
	typedef struct packed {
		op_t        op;
		logic [7:0] byte_val;
		logic       rs;
		dwell_sel_t dwell_sel;
	} cmd_t;

	// Live configuration
	typedef struct packed {
		logic       bus_mode;
		logic [7:0] pulse;
		logic [7:0] short_wait;
		logic [7:0] clear_wait;
		logic [7:0] power_up;
	} cfg_t;

	// Sequencer state
	typedef struct packed {
		phase_t     phase;
		logic [7:0] tick;
		logic [7:0] out_byte;
		logic       sel;
		logic       second;
		logic [2:0] init_step;
		logic [7:0] after_wait;
	} seq_t;

	// Configuration reset values
	localparam logic       RST_BUS_MODE   = 1'b0;
	localparam logic [7:0] RST_PULSE      = 8'd2;
	localparam logic [7:0] RST_SHORT_WAIT = 8'd1;
	localparam logic [7:0] RST_CLEAR_WAIT = 8'd10;
	localparam logic [7:0] RST_POWER_UP   = 8'd50;

	// LCD command values
	localparam logic [7:0] CURSOR_ROW1_BASE = 8'h80;
	localparam logic [7:0] CURSOR_ROW2_BASE = 8'hC0;
	localparam logic [4:0] CURSOR_COLUMNS   = 5'd16;
	localparam logic [1:0] CURSOR_ROW1      = 2'd1;
	localparam logic [1:0] CURSOR_ROW2      = 2'd2;
	localparam logic [7:0] CLEAR_CMD        = 8'h01;

	// Init command lists for eight-bit and nibble buses; index 2 is the clear
	localparam logic [7:0] INIT_CMD8 [4] = '{8'h38, 8'h0E, 8'h01, 8'h06};
	localparam logic [7:0] INIT_CMD4 [4] = '{8'h28, 8'h0F, 8'h01, 8'h06};
	localparam logic [1:0] INIT_CLEAR_IDX = 2'd2;
	localparam logic [2:0] INIT_LAST_STEP = 3'd4;

	// Queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

endpackage

/* src/lcdpws_channels.sv */
// Handshake channels of the LCD write sequencer: request, result, config write.
// No dependencies.
`timescale 1ns / 1ps

// Request channel
interface lcdpws_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic [7:0] value;
	logic [1:0] row;
	logic [4:0] column;

	modport source (output valid, kind, value, row, column, input ready);
	modport sink   (input valid, kind, value, row, column, output ready);
endinterface

// Result channel: pin levels after each tick
interface lcdpws_res_if;
	logic       valid;
	logic       ready;
	logic       enable;
	logic       register_select;
	logic [7:0] data_bus;
	logic       busy_res;
	logic       rejected;

	modport source (output valid, enable, register_select, data_bus, busy_res, rejected,
		input ready);
	modport sink   (input valid, enable, register_select, data_bus, busy_res, rejected,
		output ready);
endinterface

// Configuration write channel
interface lcdpws_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] index;
	logic [7:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

/* src/lcdpws_front.sv */
// Front end: takes request items and classifies them into queue entries.
// Depends on lcdpws_pkg and lcdpws_channels.
`timescale 1ns / 1ps

module lcdpws_front (
	lcdpws_req_if.sink          req,
	input  logic                q_full,
	output logic                push,
	output lcdpws_pkg::cmd_t    push_data
);

	logic [3:0] col_off;
	logic       col_ok;
	logic [7:0] cursor_addr;

	// Take an item whenever the queue has room
	assign req.ready = !q_full;
	assign push      = req.valid && req.ready;

	// Cursor address: row base plus column minus one, home on bad input
	assign col_off = req.column[3:0] - 4'd1;
	assign col_ok  = (req.column != 5'd0) && (req.column <= lcdpws_pkg::CURSOR_COLUMNS);

	always_comb begin
		cursor_addr = lcdpws_pkg::CURSOR_ROW1_BASE;
		if (col_ok && req.row == lcdpws_pkg::CURSOR_ROW1) begin
			cursor_addr = lcdpws_pkg::CURSOR_ROW1_BASE + {4'd0, col_off};
		end else if (col_ok && req.row == lcdpws_pkg::CURSOR_ROW2) begin
			cursor_addr = lcdpws_pkg::CURSOR_ROW2_BASE + {4'd0, col_off};
		end
	end

	// Classify by kind
	always_comb begin
		push_data.op        = lcdpws_pkg::OP_NONE;
		push_data.byte_val  = req.value;
		push_data.rs        = 1'b0;
		push_data.dwell_sel = lcdpws_pkg::DWELL_NONE;
		case (lcdpws_pkg::kind_t'(req.kind))
			lcdpws_pkg::KIND_COMMAND: begin
				push_data.op = lcdpws_pkg::OP_BYTE;
			end
			lcdpws_pkg::KIND_CHAR: begin
				push_data.op = lcdpws_pkg::OP_BYTE;
				push_data.rs = 1'b1;
			end
			lcdpws_pkg::KIND_CURSOR: begin
				push_data.op        = lcdpws_pkg::OP_BYTE;
				push_data.byte_val  = cursor_addr;
				push_data.dwell_sel = lcdpws_pkg::DWELL_SHORT;
			end
			lcdpws_pkg::KIND_CLEAR: begin
				push_data.op        = lcdpws_pkg::OP_BYTE;
				push_data.byte_val  = lcdpws_pkg::CLEAR_CMD;
				push_data.dwell_sel = lcdpws_pkg::DWELL_CLEAR;
			end
			lcdpws_pkg::KIND_INIT: begin
				push_data.op = lcdpws_pkg::OP_INIT;
			end
			default: begin
				push_data.op = lcdpws_pkg::OP_NONE;
			end
		endcase
	end

endmodule

/* src/lcdpws_queue.sv */
// Short queue of classified items between the front and back ends.
// Depends on lcdpws_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "lcd_parallel_write_sequencer_unit_assert.svh"

module lcdpws_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  lcdpws_pkg::cmd_t            push_data,
	input  logic                        pop,
	output lcdpws_pkg::cmd_t            pop_data,
	output logic                        full,
	output logic                        not_empty
);

	lcdpws_pkg::cmd_t                     mem_q [lcdpws_pkg::QUEUE_DEPTH];
	logic [lcdpws_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [lcdpws_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [lcdpws_pkg::QCNT_W-1:0]        count_q;

	localparam logic [lcdpws_pkg::QPTR_W-1:0] PTR_LAST =
		lcdpws_pkg::QPTR_W'(lcdpws_pkg::QUEUE_DEPTH - 1);
	localparam logic [lcdpws_pkg::QCNT_W-1:0] CNT_FULL =
		lcdpws_pkg::QCNT_W'(lcdpws_pkg::QUEUE_DEPTH);

	assign full      = (count_q == CNT_FULL);
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`LCDPWS_ASSERT_IMP(a_q_pop_nonempty, pop, not_empty, "queue popped while empty")
	`LCDPWS_ASSERT_IMP(a_q_push_room, push, !full, "queue pushed while full")
	`LCDPWS_ASSERT_NEXT(a_q_count_up, push && !pop, count_q == $past(count_q) + 1'b1, "queue count did not rise")

endmodule

/* src/lcdpws_back.sv */
// Back end: steps the LCD bus sequencer once per queued item, registers the pins.
// Depends on lcdpws_pkg, lcdpws_channels and the assertion macro header.
`timescale 1ns / 1ps
`include "lcd_parallel_write_sequencer_unit_assert.svh"

module lcdpws_back (
	input  logic                clk,
	input  logic                arst_n,
	input  lcdpws_pkg::cfg_t    cfg,
	input  logic                q_valid,
	input  lcdpws_pkg::cmd_t    q_data,
	output logic                pop,
	lcdpws_res_if.source        res
);

	localparam int unsigned SETTLE_STEPS = 2;

	lcdpws_pkg::seq_t seq_q;
	lcdpws_pkg::seq_t s_req;
	lcdpws_pkg::seq_t s_next;
	logic             rej;
	logic [7:0]       dwell_val;

	logic             res_valid_q;
	logic             res_enable_q;
	logic             res_rs_q;
	logic [7:0]       res_bus_q;
	logic             res_busy_q;
	logic             res_rej_q;

	logic             enable_d;
	logic [7:0]       bus_d;
	logic             busy_d;

	// Enable pulse length, zero read as one
	function automatic logic [7:0] pulse_len(lcdpws_pkg::cfg_t c);
		return (c.pulse == 8'd0) ? 8'd1 : c.pulse;
	endfunction

	// Load a byte and raise enable
	function automatic lcdpws_pkg::seq_t start_byte(lcdpws_pkg::seq_t s, logic [7:0] b,
		logic rs, logic [7:0] dwell, lcdpws_pkg::cfg_t c);
		lcdpws_pkg::seq_t r;
		r            = s;
		r.out_byte   = b;
		r.sel        = rs;
		r.second     = 1'b0;
		r.after_wait = dwell;
		r.phase      = lcdpws_pkg::PH_HIGH;
		r.tick       = pulse_len(c);
		return r;
	endfunction

	// Start the init command selected by init_step
	function automatic lcdpws_pkg::seq_t start_init(lcdpws_pkg::seq_t s, lcdpws_pkg::cfg_t c);
		logic [1:0] idx;
		logic [7:0] cmd;
		logic [7:0] dwell;
		idx   = 2'(s.init_step - 3'd1);
		cmd   = c.bus_mode ? lcdpws_pkg::INIT_CMD4[idx] : lcdpws_pkg::INIT_CMD8[idx];
		dwell = (idx == lcdpws_pkg::INIT_CLEAR_IDX) ? c.clear_wait : c.short_wait;
		return start_byte(s, cmd, 1'b0, dwell, c);
	endfunction

	// Move on from a phase whose ticks are used up
	function automatic lcdpws_pkg::seq_t finish_phase(lcdpws_pkg::seq_t s, lcdpws_pkg::cfg_t c);
		lcdpws_pkg::seq_t r;
		r = s;
		case (s.phase)
			lcdpws_pkg::PH_POWER: begin
				r.init_step = 3'd1;
				r           = start_init(r, c);
			end
			lcdpws_pkg::PH_HIGH: begin
				r.phase = lcdpws_pkg::PH_LOW;
				r.tick  = pulse_len(c);
			end
			lcdpws_pkg::PH_LOW: begin
				if (c.bus_mode && !s.second) begin
					r.second = 1'b1;
					r.phase  = lcdpws_pkg::PH_HIGH;
					r.tick   = pulse_len(c);
				end else if (c.bus_mode) begin
					r.phase = lcdpws_pkg::PH_NIBWAIT;
					r.tick  = c.short_wait;
				end else begin
					r.phase = lcdpws_pkg::PH_AFTER;
					r.tick  = s.after_wait;
				end
			end
			lcdpws_pkg::PH_NIBWAIT: begin
				r.phase = lcdpws_pkg::PH_AFTER;
				r.tick  = s.after_wait;
			end
			lcdpws_pkg::PH_AFTER: begin
				if (s.init_step != 3'd0 && s.init_step < lcdpws_pkg::INIT_LAST_STEP) begin
					r.init_step = s.init_step + 3'd1;
					r           = start_init(r, c);
				end else begin
					r.init_step = 3'd0;
					r.phase     = lcdpws_pkg::PH_IDLE;
					r.tick      = 8'd0;
				end
			end
			default: begin
				r.phase = lcdpws_pkg::PH_IDLE;
				r.tick  = 8'd0;
			end
		endcase
		return r;
	endfunction

	// Skip waits of zero length; at most two can chain before a pulse or idle
	function automatic lcdpws_pkg::seq_t settle(lcdpws_pkg::seq_t s, lcdpws_pkg::cfg_t c);
		lcdpws_pkg::seq_t r;
		r = s;
		for (int i = 0; i < SETTLE_STEPS; i++) begin
			if ((r.phase == lcdpws_pkg::PH_POWER || r.phase == lcdpws_pkg::PH_NIBWAIT ||
				r.phase == lcdpws_pkg::PH_AFTER) && r.tick == 8'd0) begin
				r = finish_phase(r, c);
			end
		end
		return r;
	endfunction

	// Pop when the result register is free or being taken
	assign pop = q_valid && (!res_valid_q || res.ready);

	// Wait that follows a requested byte
	always_comb begin
		case (q_data.dwell_sel)
			lcdpws_pkg::DWELL_SHORT: dwell_val = cfg.short_wait;
			lcdpws_pkg::DWELL_CLEAR: dwell_val = cfg.clear_wait;
			default:                 dwell_val = 8'd0;
		endcase
	end

	// Request handling: start a sequence when idle, drop it when busy
	always_comb begin
		s_req = seq_q;
		rej   = 1'b0;
		if (q_data.op != lcdpws_pkg::OP_NONE) begin
			if (seq_q.phase != lcdpws_pkg::PH_IDLE) begin
				rej = 1'b1;
			end else begin
				case (q_data.op)
					lcdpws_pkg::OP_BYTE: begin
						s_req = start_byte(seq_q, q_data.byte_val, q_data.rs, dwell_val, cfg);
					end
					lcdpws_pkg::OP_INIT: begin
						s_req.init_step = 3'd0;
						s_req.phase     = lcdpws_pkg::PH_POWER;
						s_req.tick      = cfg.power_up;
						s_req           = settle(s_req, cfg);
					end
					default: begin
						s_req = seq_q;
					end
				endcase
			end
		end
	end

	// Pin levels for this tick
	always_comb begin
		enable_d = (s_req.phase == lcdpws_pkg::PH_HIGH);
		busy_d   = (s_req.phase != lcdpws_pkg::PH_IDLE);
		if (cfg.bus_mode) begin
			bus_d = s_req.second ? {s_req.out_byte[3:0], 4'd0} : {s_req.out_byte[7:4], 4'd0};
		end else begin
			bus_d = s_req.out_byte;
		end
	end

	// Tick down the current phase and move on when it ends
	always_comb begin
		s_next = s_req;
		if (s_req.phase != lcdpws_pkg::PH_IDLE) begin
			if (s_req.tick != 8'd0) begin
				s_next.tick = s_req.tick - 8'd1;
			end
			if (s_next.tick == 8'd0) begin
				s_next = settle(finish_phase(s_next, cfg), cfg);
			end
		end
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= '{phase: lcdpws_pkg::PH_IDLE, default: '0};
		end else if (pop) begin
			seq_q <= s_next;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (pop) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (pop) begin
			res_enable_q <= enable_d;
			res_rs_q     <= s_req.sel;
			res_bus_q    <= bus_d;
			res_busy_q   <= busy_d;
			res_rej_q    <= rej;
		end
	end

	assign res.valid           = res_valid_q;
	assign res.enable          = res_enable_q;
	assign res.register_select = res_rs_q;
	assign res.data_bus        = res_bus_q;
	assign res.busy_res        = res_busy_q;
	assign res.rejected        = res_rej_q;

	`LCDPWS_ASSERT_IMP(a_bk_enable_busy, res_valid_q && res_enable_q, res_busy_q, "enable high while not busy")
	`LCDPWS_ASSERT_IMP(a_bk_reject_busy, res_valid_q && res_rej_q, res_busy_q, "request dropped while idle")
	`LCDPWS_ASSERT_IMP(a_bk_pulse_ticks, seq_q.phase == lcdpws_pkg::PH_HIGH || seq_q.phase == lcdpws_pkg::PH_LOW, seq_q.tick != 8'd0, "pulse phase with no ticks left")
	`LCDPWS_ASSERT_NEXT(a_bk_pop_loads, pop, res_valid_q, "popped item gave no result")

endmodule

/* src/lcd_parallel_write_sequencer_unit.sv */
// Character LCD parallel write sequencer. Every item on req is one time tick, and
// may carry a request: command byte, character, cursor move, clear or power-up
// init. Every item gives exactly one item on res with the enable, register select
// and data pin levels after that tick, plus busy and a flag for a request dropped
// while busy. The block takes one item per clock cycle while res is not held off:
// the front end classifies it into a two-entry queue and the back end applies one
// sequencer step per cycle, and each item is held in the queue and its result is
// then held in the result register until taken from res. While res is held off the
// back end stops, and the queue fills up to its two entries before req.ready falls.
// cfg is always ready; write it only while the block is idle. No clearing pass
// after reset. Depends on lcdpws_pkg, lcdpws_channels, lcdpws_front,
// lcdpws_queue and lcdpws_back.
`timescale 1ns / 1ps

module lcd_parallel_write_sequencer_unit (
	input  logic          clk,
	input  logic          arst_n,
	lcdpws_req_if.sink    req,
	lcdpws_res_if.source  res,
	lcdpws_cfg_if.sink    cfg
);

	lcdpws_pkg::cfg_t cfg_q;
	lcdpws_pkg::cmd_t push_data;
	lcdpws_pkg::cmd_t pop_data;
	logic             push;
	logic             pop;
	logic             q_full;
	logic             q_valid;

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bus_mode   <= lcdpws_pkg::RST_BUS_MODE;
			cfg_q.pulse      <= lcdpws_pkg::RST_PULSE;
			cfg_q.short_wait <= lcdpws_pkg::RST_SHORT_WAIT;
			cfg_q.clear_wait <= lcdpws_pkg::RST_CLEAR_WAIT;
			cfg_q.power_up   <= lcdpws_pkg::RST_POWER_UP;
		end else if (cfg.valid && cfg.ready) begin
			case (lcdpws_pkg::cfg_idx_t'(cfg.index))
				lcdpws_pkg::CFG_BUS_MODE:   cfg_q.bus_mode   <= cfg.data[0];
				lcdpws_pkg::CFG_PULSE:      cfg_q.pulse      <= cfg.data;
				lcdpws_pkg::CFG_SHORT_WAIT: cfg_q.short_wait <= cfg.data;
				lcdpws_pkg::CFG_CLEAR_WAIT: cfg_q.clear_wait <= cfg.data;
				lcdpws_pkg::CFG_POWER_UP:   cfg_q.power_up   <= cfg.data;
				default:                    cfg_q            <= cfg_q;
			endcase
		end
	end

	// Request intake and classification
	lcdpws_front u_front (
		.req       (req),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	// Decoupling queue
	lcdpws_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (q_full),
		.not_empty (q_valid)
	);

	// Bus sequencer and result register
	lcdpws_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_data  (pop_data),
		.pop     (pop),
		.res     (res)
	);

endmodule
